[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, reset by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic check with a fixed message
`define RBAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rbam assertion failed");

// check with a caller message
`define RBAM_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

[hdl/rbam_pkg.sv]
// ----------------------------------------------------------------------------
// rbam_pkg
// widths, codes and stage payload types of the radial brush alpha mask
// ----------------------------------------------------------------------------
package rbam_pkg;

  localparam int MAX_DIAMETER = 512;
  localparam int ROW_W   = 9;
  localparam int DIA_W   = 10;
  localparam int ALPHA_W = 16;
  localparam int S_W     = 18;
  localparam int DD_W    = 19;
  localparam int X_W     = 52;
  localparam int ROOT_W  = 26;
  localparam int REM_W   = ROOT_W + 2;
  localparam int NUM_W   = 36;
  localparam int N_W     = 37;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'hFFFF;
  localparam logic [DIA_W-1:0]   DIA_MAX   = DIA_W'(MAX_DIAMETER);

  typedef enum logic [1:0] {
    FALLOFF_CONST  = 2'd0,
    FALLOFF_LINEAR = 2'd1,
    FALLOFF_QUAD   = 2'd2
  } falloff_e;

  localparam logic REG_FALLOFF_MODE   = 1'b0;
  localparam logic REG_BRUSH_DIAMETER = 1'b1;

  typedef struct packed {
    logic             vld;
    logic             in_disk;
    logic [X_W-1:0]   x;
    logic [NUM_W-1:0] num;
  } front_t;

  typedef struct packed {
    logic              vld;
    logic              in_disk;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] root;
    logic              exact;
  } root_t;

  typedef struct packed {
    logic               vld;
    logic               in_disk;
    logic [ALPHA_W-1:0] up;
  } quot_t;

endpackage

[hdl/rbam_front.sv]
// ----------------------------------------------------------------------------
// rbam_front
// three stages: axis offsets, squared distance, disk test and scaled operands
// ----------------------------------------------------------------------------
module rbam_front import rbam_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [ROW_W-1:0] col_i,
  input  logic [DIA_W-1:0] dia_i,
  input  logic [DD_W-1:0]  dd_i,
  output front_t           front_o
);

  logic             vld1_q, vld2_q, vld3_q;
  logic             win1_q, win1_d, win2_q;
  logic [ROW_W-1:0] dr1_q, dr1_d, dc1_q, dc1_d;
  logic [S_W-1:0]   s2_q, s2_d;
  logic [ROW_W-1:0] ctr;
  front_t           front_q, front_d;

  assign ctr = dia_i[DIA_W-1:1];

  always_comb begin
    win1_d = (dia_i != '0) && ({1'b0, row_i} < dia_i) && ({1'b0, col_i} < dia_i);
    dr1_d  = (row_i >= ctr) ? row_i - ctr : ctr - row_i;
    dc1_d  = (col_i >= ctr) ? col_i - ctr : ctr - col_i;
    s2_d   = S_W'(dr1_q) * S_W'(dr1_q) + S_W'(dc1_q) * S_W'(dc1_q);
  end

  always_comb begin
    front_d.vld     = vld2_q;
    front_d.in_disk = win2_q && ({s2_q, 2'b00} < {1'b0, dd_i});
    front_d.x       = {s2_q, 34'b0} - {15'b0, s2_q, 19'b0} + {32'b0, s2_q, 2'b00};
    front_d.num     = {s2_q, 18'b0} - {16'b0, s2_q, 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      win1_q  <= win1_d;
      dr1_q   <= dr1_d;
      dc1_q   <= dc1_d;
      win2_q  <= win1_q;
      s2_q    <= s2_d;
      front_q <= front_d;
    end
  end

  always_comb begin
    front_o     = front_q;
    front_o.vld = vld3_q;
  end

endmodule

[hdl/rbam_isqrt.sv]
// ----------------------------------------------------------------------------
// rbam_isqrt
// pipelined restoring square root, one root bit per stage
// ----------------------------------------------------------------------------
module rbam_isqrt import rbam_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  front_t front_i,
  output root_t  root_o
);

  logic              vld_q     [ROOT_W];
  logic              in_disk_q [ROOT_W];
  logic [X_W-1:0]    x_q       [ROOT_W];
  logic [NUM_W-1:0]  num_q     [ROOT_W];
  logic [REM_W-1:0]  rem_q     [ROOT_W];
  logic [ROOT_W-1:0] root_q    [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic              vld_in, in_disk_in;
    logic [X_W-1:0]    x_in;
    logic [NUM_W-1:0]  num_in;
    logic [REM_W-1:0]  rem_in, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;
    logic [REM_W+1:0]  rem_sh, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in     = front_i.vld;
      assign in_disk_in = front_i.in_disk;
      assign x_in       = front_i.x;
      assign num_in     = front_i.num;
      assign rem_in     = '0;
      assign root_in    = '0;
    end else begin : g_next
      assign vld_in     = vld_q[k-1];
      assign in_disk_in = in_disk_q[k-1];
      assign x_in       = x_q[k-1];
      assign num_in     = num_q[k-1];
      assign rem_in     = rem_q[k-1];
      assign root_in    = root_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, x_in[2*B+1 -: 2]};
      trial  = {2'b00, root_in, 2'b01};
      ge     = rem_sh >= trial;
      rem_d  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_d = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        in_disk_q[k] <= in_disk_in;
        x_q[k]       <= x_in;
        num_q[k]     <= num_in;
        rem_q[k]     <= rem_d;
        root_q[k]    <= root_d;
      end
    end
  end

  always_comb begin
    root_o.vld     = vld_q[ROOT_W-1];
    root_o.in_disk = in_disk_q[ROOT_W-1];
    root_o.num     = num_q[ROOT_W-1];
    root_o.root    = root_q[ROOT_W-1];
    root_o.exact   = rem_q[ROOT_W-1] == '0;
  end

endmodule

[hdl/rbam_cdiv.sv]
// ----------------------------------------------------------------------------
// rbam_cdiv
// operand select and pipelined ceiling division, one quotient bit per stage
// ----------------------------------------------------------------------------
module rbam_cdiv import rbam_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  root_t            root_i,
  input  logic [1:0]       mode_i,
  input  logic [DIA_W-1:0] dia_i,
  input  logic [DD_W-1:0]  dd_i,
  output quot_t            quot_o
);

  logic            sel_vld_q, sel_in_disk_q;
  logic [N_W-1:0]  sel_n_q, sel_n_d;
  logic [DD_W-1:0] sel_d_q, sel_d_d;

  // ceil(n/d) as floor((n+d-1)/d); the linear root is bumped when not exact
  always_comb begin
    if (mode_i == FALLOFF_QUAD) begin
      sel_n_d = {1'b0, root_i.num} + {18'b0, dd_i} - N_W'(1);
      sel_d_d = dd_i;
    end else begin
      sel_n_d = {11'b0, root_i.root} + {36'b0, !root_i.exact} + {27'b0, dia_i} - N_W'(1);
      sel_d_d = {9'b0, dia_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
    end else if (en_i) begin
      sel_vld_q <= root_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_in_disk_q <= root_i.in_disk;
      sel_n_q       <= sel_n_d;
      sel_d_q       <= sel_d_d;
    end
  end

  logic               vld_q     [ALPHA_W];
  logic               in_disk_q [ALPHA_W];
  logic [N_W-1:0]     n_q       [ALPHA_W];
  logic [DD_W-1:0]    d_q       [ALPHA_W];
  logic [ALPHA_W-1:0] q_q       [ALPHA_W];

  for (genvar j = 0; j < ALPHA_W; j++) begin : g_stage
    localparam int B = ALPHA_W - 1 - j;
    logic               vld_in, in_disk_in, ge;
    logic [N_W-1:0]     n_in, n_d, dsh;
    logic [DD_W-1:0]    d_in;
    logic [ALPHA_W-1:0] q_in, q_d;

    if (j == 0) begin : g_first
      assign vld_in     = sel_vld_q;
      assign in_disk_in = sel_in_disk_q;
      assign n_in       = sel_n_q;
      assign d_in       = sel_d_q;
      assign q_in       = '0;
    end else begin : g_next
      assign vld_in     = vld_q[j-1];
      assign in_disk_in = in_disk_q[j-1];
      assign n_in       = n_q[j-1];
      assign d_in       = d_q[j-1];
      assign q_in       = q_q[j-1];
    end

    always_comb begin
      dsh = {18'b0, d_in} << B;
      ge  = n_in >= dsh;
      n_d = ge ? n_in - dsh : n_in;
      q_d = q_in | (ALPHA_W'(ge) << B);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        in_disk_q[j] <= in_disk_in;
        n_q[j]       <= n_d;
        d_q[j]       <= d_in;
        q_q[j]       <= q_d;
      end
    end
  end

  always_comb begin
    quot_o.vld     = vld_q[ALPHA_W-1];
    quot_o.in_disk = in_disk_q[ALPHA_W-1];
    quot_o.up      = q_q[ALPHA_W-1];
  end

endmodule

[hdl/radial_brush_alpha_mask.sv]
// ----------------------------------------------------------------------------
// radial_brush_alpha_mask
// alpha of one position in a square airbrush window with radial falloff
// ----------------------------------------------------------------------------
// usage:
//   input channel: mask_row_i / mask_col_i with in_valid_i, in_stall_o.
//   output channel: alpha_value_o / inside_disk_o with out_valid_o, out_stall_i.
//   a transaction moves when valid is high and stall is low at a clock edge.
//   configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0 falloff_mode, 1 brush_diameter); write only while the pipeline is empty.
// path: an input transaction passes the 3 geometry stages, the 26-stage
//   square root, the operand select plus 16-stage divider, and the output
//   register.
// throughput: one transaction per cycle unless stalled, every stage is a single register.
// reset: clears all valid bits, falloff_mode to linear, brush_diameter to 10.
// stall: while a result waits and out_stall_i is high the whole pipeline
//   holds and in_stall_o is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module radial_brush_alpha_mask import rbam_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ROW_W-1:0]   mask_row_i,
  input  logic [ROW_W-1:0]   mask_col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ALPHA_W-1:0] alpha_value_o,
  output logic               inside_disk_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [DIA_W-1:0]   cfg_data_i
);

  logic [1:0]         falloff_mode_q;
  logic [DIA_W-1:0]   brush_diameter_q;
  logic [DIA_W-1:0]   dia_eff;
  logic [DD_W-1:0]    dd_q;
  logic               en;
  logic               const_mode;
  front_t             front;
  root_t              root;
  quot_t              quot;
  logic               out_vld_q;
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic               inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      falloff_mode_q   <= FALLOFF_LINEAR;
      brush_diameter_q <= DIA_W'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FALLOFF_MODE:   falloff_mode_q   <= cfg_data_i[1:0];
        REG_BRUSH_DIAMETER: brush_diameter_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dia_eff = (brush_diameter_q > DIA_MAX) ? DIA_MAX : brush_diameter_q;

  // squared diameter is registered and follows the register in the cycle after
  always_ff @(posedge clk_i) begin
    dd_q <= DD_W'(dia_eff) * DD_W'(dia_eff);
  end

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  rbam_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .row_i   (mask_row_i),
    .col_i   (mask_col_i),
    .dia_i   (dia_eff),
    .dd_i    (dd_q),
    .front_o (front)
  );

  rbam_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .front_i (front),
    .root_o  (root)
  );

  rbam_cdiv u_cdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .root_i (root),
    .mode_i (falloff_mode_q),
    .dia_i  (dia_eff),
    .dd_i   (dd_q),
    .quot_o (quot)
  );

  always_comb begin
    alpha_d = '0;
    if (quot.in_disk) begin
      case (falloff_mode_q) inside
        FALLOFF_CONST:  alpha_d = ALPHA_ONE;
        FALLOFF_LINEAR,
        FALLOFF_QUAD:   alpha_d = (quot.up == ALPHA_ONE) ? '0 : ALPHA_ONE - quot.up;
        default:        alpha_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= quot.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q  <= alpha_d;
      inside_q <= quot.in_disk;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign alpha_value_o = alpha_q;
  assign inside_disk_o = inside_q;

  assign const_mode = (falloff_mode_q == FALLOFF_CONST);

`include "assert_macros.svh"

  `RBAM_ASSERT(a_alpha_needs_disk, out_valid_o && (alpha_value_o != '0) |-> inside_disk_o)
  `RBAM_ASSERT_MSG(a_stall_follows_output, in_stall_o == (out_valid_o && out_stall_i), "stall mismatch")
  `RBAM_ASSERT(a_const_full, out_valid_o && inside_disk_o && const_mode |-> (alpha_value_o == ALPHA_ONE))

endmodule
